// File: design/volume_gradient_normal_quantizer_assert.svh
// Assertion macros used by the RTL of the gradient quantizer.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef VOLUME_GRADIENT_NORMAL_QUANTIZER_ASSERT_SVH
`define VOLUME_GRADIENT_NORMAL_QUANTIZER_ASSERT_SVH

// Same-cycle implication.
`define VGNQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define VGNQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/vgnq_pkg.sv
package vgnq_pkg;

  localparam int unsigned MaxDimDefault      = 128;
  localparam int unsigned WindowDepthDefault = 32768;

  localparam int unsigned VoxW    = 8;
  localparam int unsigned CfgW    = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgW-1:0] SizeReset = 8'd128;

  localparam logic KindVoxel = 1'b0;
  localparam logic KindFlush = 1'b1;

  localparam logic [7:0]  QMid = 8'd127;
  localparam logic [13:0] QSq  = 14'd16129;

  localparam int unsigned TermW = 10;  // signed axis term, |a| <= 510
  localparam int unsigned SumW  = 20;  // sum of three squared terms
  localparam int unsigned MulAW = 20;
  localparam int unsigned MulBW = 14;
  localparam int unsigned MulW  = 34;
  localparam int unsigned RhsW  = 32;
  localparam int unsigned QW    = 7;   // magnitude of the quantized offset

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SIZE_X = 2'd0,
    CFG_SIZE_Y = 2'd1,
    CFG_SIZE_Z = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    NB_C = 3'd0,
    NB_L = 3'd1,
    NB_R = 3'd2,
    NB_T = 3'd3,
    NB_B = 3'd4,
    NB_F = 3'd5,
    NB_K = 3'd6
  } nbr_e;

  typedef enum logic [1:0] {
    MUL_TERM = 2'd0,
    MUL_RHS  = 2'd1,
    MUL_CAND = 2'd2,
    MUL_PROD = 2'd3
  } mul_op_e;

  typedef enum logic [13:0] {
    S_SETUP1 = 14'h0001,
    S_SETUP2 = 14'h0002,
    S_IDLE   = 14'h0004,
    S_READ   = 14'h0008,
    S_TERMS  = 14'h0010,
    S_SQ     = 14'h0020,
    S_RHS1   = 14'h0040,
    S_RHS2   = 14'h0080,
    S_RHS3   = 14'h0100,
    S_STA    = 14'h0200,
    S_STB    = 14'h0400,
    S_STC    = 14'h0800,
    S_FIN    = 14'h1000,
    S_DONE   = 14'h2000
  } state_e;

  typedef struct packed {
    logic       setup_plane;
    logic       setup_total;
    logic       accept;
    logic       rd_en;
    nbr_e       rd_sel;
    logic       cap_en;
    nbr_e       cap_sel;
    logic       terms_en;
    mul_op_e    mul_op;
    logic [1:0] comp;
    logic [2:0] bit_idx;
    logic       s_clr;
    logic       s_acc;
    logic       rhs_ld;
    logic       step_upd;
    logic       fin;
    logic       commit;
  } cmd_t;

  typedef struct packed {
    logic cfg_hit;
    logic emit;
    logic out_busy;
  } status_t;

  // lo - hi, doubled when only one neighbor exists, zero when none does
  function automatic logic signed [TermW-1:0] axis_term(input logic [VoxW-1:0] lo,
                                                        input logic [VoxW-1:0] hi,
                                                        input logic [1:0]      cnt);
    logic signed [TermW-1:0] d;
    logic signed [TermW-1:0] r;
    d = $signed({2'b00, lo}) - $signed({2'b00, hi});
    unique case (cnt)
      2'd0: r = '0;
      2'd1: r = d <<< 1;
      default: r = d;
    endcase
    return r;
  endfunction

endpackage

// File: design/vgnq_ram.sv
module vgnq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/vgnq_ctrl.sv
module vgnq_ctrl import vgnq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam logic [2:0] RdLast = 3'd7;
  localparam logic [2:0] SqLast = 3'd3;
  localparam logic [2:0] BitTop = 3'(QW - 1);

  state_e     state_q, state_d;
  logic [2:0] cnt_q, cnt_d;
  logic [1:0] comp_q, comp_d;
  logic       accept;

  assign in_stall_o = (state_q != S_IDLE) || status_i.cfg_hit;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    comp_d        = comp_q;
    cmd_o         = '0;
    cmd_o.accept  = accept;
    cmd_o.comp    = comp_q;
    cmd_o.bit_idx = cnt_q;
    cmd_o.rd_sel  = nbr_e'(cnt_q);
    cmd_o.cap_sel = nbr_e'(cnt_q - 3'd1);
    cmd_o.mul_op  = MUL_TERM;
    if (status_i.cfg_hit) begin
      state_d = S_SETUP1;
    end else begin
      unique case (state_q)
        S_SETUP1: begin
          cmd_o.setup_plane = 1'b1;
          state_d = S_SETUP2;
        end
        S_SETUP2: begin
          cmd_o.setup_total = 1'b1;
          state_d = S_IDLE;
        end
        S_IDLE: begin
          if (accept && status_i.emit) begin
            cnt_d   = '0;
            state_d = S_READ;
          end
        end
        S_READ: begin
          // issue one read a cycle, capture the previous one
          cmd_o.rd_en  = (cnt_q != RdLast);
          cmd_o.cap_en = (cnt_q != '0);
          if (cnt_q == RdLast) begin
            state_d = S_TERMS;
          end else begin
            cnt_d = cnt_q + 3'd1;
          end
        end
        S_TERMS: begin
          cmd_o.terms_en = 1'b1;
          cnt_d   = '0;
          state_d = S_SQ;
        end
        S_SQ: begin
          cmd_o.comp  = cnt_q[1:0];
          cmd_o.s_clr = (cnt_q == '0);
          cmd_o.s_acc = (cnt_q != '0);
          if (cnt_q == SqLast) begin
            comp_d  = '0;
            state_d = S_RHS1;
          end else begin
            cnt_d = cnt_q + 3'd1;
          end
        end
        S_RHS1: begin
          state_d = S_RHS2;
        end
        S_RHS2: begin
          cmd_o.mul_op = MUL_RHS;
          state_d = S_RHS3;
        end
        S_RHS3: begin
          cmd_o.rhs_ld = 1'b1;
          cnt_d   = BitTop;
          state_d = S_STA;
        end
        S_STA: begin
          cmd_o.mul_op = MUL_CAND;
          state_d = S_STB;
        end
        S_STB: begin
          cmd_o.mul_op = MUL_PROD;
          state_d = S_STC;
        end
        S_STC: begin
          cmd_o.step_upd = 1'b1;
          if (cnt_q == '0) begin
            state_d = S_FIN;
          end else begin
            cnt_d   = cnt_q - 3'd1;
            state_d = S_STA;
          end
        end
        S_FIN: begin
          cmd_o.fin = 1'b1;
          if (comp_q == 2'd2) begin
            state_d = S_DONE;
          end else begin
            comp_d  = comp_q + 2'd1;
            state_d = S_RHS1;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!status_i.out_busy) begin
            cmd_o.commit = 1'b1;
            state_d = S_IDLE;
          end
        end
        default: begin
          state_d = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SETUP1;
      cnt_q   <= '0;
      comp_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      comp_q  <= comp_d;
    end
  end

endmodule

// File: design/vgnq_dp.sv
`include "volume_gradient_normal_quantizer_assert.svh"

module vgnq_dp import vgnq_pkg::*; #(
  parameter int unsigned MAX_DIM      = MaxDimDefault,
  parameter int unsigned WINDOW_DEPTH = WindowDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               kind_i,
  input  logic [VoxW-1:0]    value_i,
  input  logic               out_stall_i,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  output logic               out_valid_o,
  output logic [7:0]         grad_x_o,
  output logic [7:0]         grad_y_o,
  output logic [7:0]         grad_z_o,
  output logic [VoxW-1:0]    voxel_o,
  output logic               last_o
);

  localparam int unsigned DW  = $clog2(MAX_DIM + 1);
  localparam int unsigned CW  = $clog2(MAX_DIM);
  localparam int unsigned PLW = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int unsigned PW  = $clog2(MAX_DIM * MAX_DIM * MAX_DIM + 1);
  localparam int unsigned AW  = $clog2(WINDOW_DEPTH);
  localparam int unsigned LW  = (PW > AW) ? PW : AW;

  function automatic logic [DW-1:0] eff_size(input logic [CfgW-1:0] v);
    logic [DW-1:0] r;
    if (v == '0) begin
      r = DW'(1);
    end else if (32'(v) > MAX_DIM) begin
      r = DW'(MAX_DIM);
    end else begin
      r = DW'(v);
    end
    return r;
  endfunction

  logic [CfgW-1:0] size_x_q, size_y_q, size_z_q;
  logic [DW-1:0]   ex, ey, ez;
  logic [PLW-1:0]  plane_q;
  logic [PW-1:0]   total_q;
  logic [PW-1:0]   in_pos_q, out_pos_q, out_next;
  logic [CW-1:0]   x_q, y_q, z_q;
  logic            cfg_hit;

  logic vox_ok, at_lag, emit_new_c, store_c, flush_c, last_c;
  logic has_l, has_r, has_t, has_b, has_f, has_k;

  logic            new_q;
  logic [VoxW-1:0] new_val_q;
  logic [VoxW-1:0] vc_q, vl_q, vr_q, vt_q, vb_q, vf_q, vk_q;

  logic signed [TermW-1:0] ax_q, ay_q, az_q, a_sel;
  logic        [TermW-1:0] m_sel;
  logic                    a_neg;

  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [MulW-1:0]  mul_q;
  logic [SumW-1:0]  s_q;
  logic [RhsW-1:0]  rhs_q;
  logic [QW-1:0]    u_q, cand, t_neg;
  logic             s_zero, step_ok;
  logic [7:0]       q_val;
  logic [7:0]       gx_q, gy_q, gz_q;

  logic [LW-1:0] c_l, in_l, rd_l;
  logic          ram_we, ram_re;
  logic [VoxW-1:0] ram_wdata, ram_rdata;

  logic            out_valid_q;
  logic [7:0]      out_gx_q, out_gy_q, out_gz_q;
  logic [VoxW-1:0] out_vox_q;
  logic            out_last_q;

  // --- configuration ---
  always_comb begin
    unique case (cfg_idx_i)
      CFG_SIZE_X, CFG_SIZE_Y, CFG_SIZE_Z: cfg_hit = cfg_we_i;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= SizeReset;
      size_y_q <= SizeReset;
      size_z_q <= SizeReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SIZE_X: size_x_q <= cfg_wdata_i;
        CFG_SIZE_Y: size_y_q <= cfg_wdata_i;
        CFG_SIZE_Z: size_z_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign ex = eff_size(size_x_q);
  assign ey = eff_size(size_y_q);
  assign ez = eff_size(size_z_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup_plane) begin
      plane_q <= PLW'(ex) * PLW'(ey);
    end
    if (cmd_i.setup_total) begin
      total_q <= PW'(plane_q) * PW'(ez);
    end
  end

  // --- item decision ---
  assign vox_ok     = in_pos_q < total_q;
  assign at_lag     = (out_pos_q + PW'(plane_q)) == in_pos_q;
  assign emit_new_c = (kind_i == KindVoxel) && vox_ok && at_lag;
  assign store_c    = (kind_i == KindVoxel) && vox_ok && !at_lag;
  assign flush_c    = (kind_i == KindFlush) && (in_pos_q == total_q) && (out_pos_q < total_q);
  assign out_next   = out_pos_q + PW'(1);
  assign last_c     = out_next == total_q;

  assign status_o.cfg_hit  = cfg_hit;
  assign status_o.emit     = emit_new_c || flush_c;
  assign status_o.out_busy = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      new_q <= 1'b0;
    end else if (cmd_i.accept && status_o.emit) begin
      new_q <= emit_new_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && status_o.emit) begin
      new_val_q <= value_i;
    end
  end

  // --- positions ---
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_pos_q  <= '0;
      out_pos_q <= '0;
      x_q       <= '0;
      y_q       <= '0;
      z_q       <= '0;
    end else if (cfg_hit) begin
      in_pos_q  <= '0;
      out_pos_q <= '0;
      x_q       <= '0;
      y_q       <= '0;
      z_q       <= '0;
    end else if (cmd_i.accept && store_c) begin
      in_pos_q <= in_pos_q + PW'(1);
    end else if (cmd_i.commit) begin
      if (out_next >= total_q) begin
        // volume complete: start over
        in_pos_q  <= '0;
        out_pos_q <= '0;
        x_q       <= '0;
        y_q       <= '0;
        z_q       <= '0;
      end else begin
        if (new_q) begin
          in_pos_q <= in_pos_q + PW'(1);
        end
        out_pos_q <= out_next;
        if ((DW'(x_q) + DW'(1)) == ex) begin
          x_q <= '0;
          if ((DW'(y_q) + DW'(1)) == ey) begin
            y_q <= '0;
            z_q <= z_q + CW'(1);
          end else begin
            y_q <= y_q + CW'(1);
          end
        end else begin
          x_q <= x_q + CW'(1);
        end
      end
    end
  end

  // --- window memory ---
  assign has_l = x_q != '0;
  assign has_r = (DW'(x_q) + DW'(1)) < ex;
  assign has_t = y_q != '0;
  assign has_b = (DW'(y_q) + DW'(1)) < ey;
  assign has_f = z_q != '0;
  assign has_k = (DW'(z_q) + DW'(1)) < ez;

  assign c_l  = LW'(out_pos_q);
  assign in_l = LW'(in_pos_q);

  // absent neighbors read the center
  always_comb begin
    unique case (cmd_i.rd_sel)
      NB_L:    rd_l = has_l ? c_l - LW'(1) : c_l;
      NB_R:    rd_l = has_r ? c_l + LW'(1) : c_l;
      NB_T:    rd_l = has_t ? c_l - LW'(ex) : c_l;
      NB_B:    rd_l = has_b ? c_l + LW'(ex) : c_l;
      NB_F:    rd_l = has_f ? c_l - LW'(plane_q) : c_l;
      NB_K:    rd_l = has_k ? c_l + LW'(plane_q) : c_l;
      default: rd_l = c_l;
    endcase
  end

  assign ram_we    = (cmd_i.accept && store_c) || (cmd_i.commit && new_q);
  assign ram_wdata = cmd_i.commit ? new_val_q : value_i;
  assign ram_re    = cmd_i.rd_en;

  vgnq_ram #(
    .WIDTH (VoxW),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_l[AW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_l[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_en) begin
      unique case (cmd_i.cap_sel)
        NB_C: vc_q <= ram_rdata;
        NB_L: vl_q <= ram_rdata;
        NB_R: vr_q <= ram_rdata;
        NB_T: vt_q <= ram_rdata;
        NB_B: vb_q <= ram_rdata;
        NB_F: vf_q <= ram_rdata;
        NB_K: vk_q <= (new_q && has_k) ? new_val_q : ram_rdata;
        default: ;
      endcase
    end
  end

  // --- gradient terms ---
  always_ff @(posedge clk_i) begin
    if (cmd_i.terms_en) begin
      ax_q <= axis_term(vl_q, vr_q, {1'b0, has_l} + {1'b0, has_r});
      ay_q <= axis_term(vt_q, vb_q, {1'b0, has_t} + {1'b0, has_b});
      az_q <= axis_term(vf_q, vk_q, {1'b0, has_f} + {1'b0, has_k});
    end
  end

  always_comb begin
    unique case (cmd_i.comp)
      2'd0:    a_sel = ax_q;
      2'd1:    a_sel = ay_q;
      default: a_sel = az_q;
    endcase
  end

  assign a_neg = a_sel < 0;
  assign m_sel = a_neg ? TermW'(-a_sel) : TermW'(a_sel);
  assign cand  = u_q | (QW'(1) << cmd_i.bit_idx);

  // --- shared multiplier ---
  always_comb begin
    unique case (cmd_i.mul_op)
      MUL_TERM: begin
        mul_a = MulAW'(m_sel);
        mul_b = MulBW'(m_sel);
      end
      MUL_RHS: begin
        mul_a = mul_q[MulAW-1:0];
        mul_b = QSq;
      end
      MUL_CAND: begin
        mul_a = MulAW'(cand);
        mul_b = MulBW'(cand);
      end
      default: begin
        mul_a = s_q;
        mul_b = mul_q[MulBW-1:0];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_q <= MulW'(mul_a) * MulW'(mul_b);
  end

  // --- normalization search: largest u with u^2*s against 127^2*a^2 ---
  assign step_ok = a_neg ? (mul_q < MulW'(rhs_q)) : (mul_q <= MulW'(rhs_q));
  assign s_zero  = s_q == '0;
  assign t_neg   = (u_q == '1) ? u_q : u_q + QW'(1);

  always_comb begin
    if (s_zero) begin
      q_val = QMid;
    end else if (a_neg) begin
      q_val = QMid - 8'(t_neg);
    end else begin
      q_val = QMid + 8'(u_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.s_clr) begin
      s_q <= '0;
    end else if (cmd_i.s_acc) begin
      s_q <= s_q + mul_q[SumW-1:0];
    end
    if (cmd_i.rhs_ld) begin
      rhs_q <= mul_q[RhsW-1:0];
      u_q   <= '0;
    end else if (cmd_i.step_upd && step_ok) begin
      u_q <= cand;
    end
    if (cmd_i.fin) begin
      unique case (cmd_i.comp)
        2'd0:    gx_q <= q_val;
        2'd1:    gy_q <= q_val;
        default: gz_q <= q_val;
      endcase
    end
  end

  // --- output register ---
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_gx_q   <= gx_q;
      out_gy_q   <= gy_q;
      out_gz_q   <= gz_q;
      out_vox_q  <= vc_q;
      out_last_q <= last_c;
    end
  end

  assign out_valid_o = out_valid_q;
  assign grad_x_o    = out_gx_q;
  assign grad_y_o    = out_gy_q;
  assign grad_z_o    = out_gz_q;
  assign voxel_o     = out_vox_q;
  assign last_o      = out_last_q;

  `VGNQ_ASSERT_IMPL(a_commit_free, cmd_i.commit, !(out_valid_q && out_stall_i), "result overwritten while held")
  `VGNQ_ASSERT_NEXT(a_store_advance, cmd_i.accept && store_c, in_pos_q == $past(in_pos_q) + PW'(1), "store did not advance input position")
  `VGNQ_ASSERT_NEXT(a_volume_wrap, cmd_i.commit && last_c, (in_pos_q == '0) && (out_pos_q == '0), "positions not cleared at end of volume")

endmodule

// File: design/volume_gradient_normal_quantizer.sv
// Voxels that only fill the window are taken one per cycle while the block is idle and no size is written.
// A voxel or flush that completes a result stalls the input until its result is committed to the
// output register: 7 window reads, then a shared multiplier runs a 7-step search per axis.
// Reset clears positions, sets all sizes to 128 and runs the plane and total setup states; a size write
// restarts the volume with the same setup. Window memory is not cleared.
module volume_gradient_normal_quantizer import vgnq_pkg::*; #(
  parameter int unsigned MAX_DIM      = MaxDimDefault,
  parameter int unsigned WINDOW_DEPTH = WindowDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  input  logic [VoxW-1:0]    value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         grad_x_o,
  output logic [7:0]         grad_y_o,
  output logic [7:0]         grad_z_o,
  output logic [VoxW-1:0]    voxel_o,
  output logic               last_o
);

  cmd_t    cmd;
  status_t status;

  vgnq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  vgnq_dp #(
    .MAX_DIM      (MAX_DIM),
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .kind_i      (kind_i),
    .value_i     (value_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .grad_x_o    (grad_x_o),
    .grad_y_o    (grad_y_o),
    .grad_z_o    (grad_z_o),
    .voxel_o     (voxel_o),
    .last_o      (last_o)
  );

endmodule

// File: tb/sv/tb_volume_gradient_normal_quantizer.sv
`timescale 1ns / 100ps

module tb_volume_gradient_normal_quantizer;
  import vgnq_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 2'd3;
  localparam int NumPhases = 10;
  localparam int PhaseItems = 100;
  localparam int DrainCycles = 200;
  localparam longint CycleLimit = 3000000;
  localparam int WinDepth = 32768;

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
  } voxel_item_t;

  typedef struct packed {
    logic [7:0] gx;
    logic [7:0] gy;
    logic [7:0] gz;
    logic [7:0] voxel;
    logic       last;
  } normal_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0] cfg_wdata_i;
  logic in_valid_i, in_stall_o, kind_i;
  logic [VoxW-1:0] value_i;
  logic out_valid_o, out_stall_i;
  logic [7:0] grad_x_o, grad_y_o, grad_z_o;
  logic [VoxW-1:0] voxel_o;
  logic last_o;

  volume_gradient_normal_quantizer uut (.*);

  voxel_item_t pending_items[$];
  normal_t expected_normals[$];
  int errors = 0;
  longint cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // shadow of the block state
  logic [7:0] win_mem[WinDepth];
  int unsigned in_pos, out_pos;
  logic [7:0] size_reg[3];

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int unsigned eff_size(logic [7:0] r);
    if (r == 0) return 1;
    if (r > 128) return 128;
    return r;
  endfunction

  function automatic int unsigned win_read(int unsigned idx, bit has_new, int unsigned val);
    if (has_new && idx == in_pos) return val;
    return win_mem[idx % WinDepth];
  endfunction

  function automatic int dir_term(int unsigned lo, int unsigned hi, int unsigned cnt);
    int d;
    d = int'(lo) - int'(hi);
    if (cnt == 0) return 0;
    if (cnt == 1) return 2 * d;
    return d;
  endfunction

  function automatic logic [7:0] quantize(int a, longint s);
    longint m, rhs, t;
    m = (a < 0) ? -a : a;
    rhs = 16129 * m * m;
    t = 0;
    if (a >= 0) begin
      while (t < 127 && (t + 1) * (t + 1) * s <= rhs) t++;
      return 8'(127 + t);
    end
    while (t < 127 && t * t * s < rhs) t++;
    return 8'(127 - t);
  endfunction

  function automatic normal_t gradient_at(bit has_new, int unsigned val);
    int unsigned sx, sy, sz, plane, c, x, y, z, l, r, t, b, f, k, nx, ny, nz;
    int ax, ay, az;
    longint s;
    normal_t n;
    sx = eff_size(size_reg[0]);
    sy = eff_size(size_reg[1]);
    sz = eff_size(size_reg[2]);
    plane = sx * sy;
    c = out_pos;
    x = c % sx; y = (c / sx) % sy; z = c / plane;
    l = c; r = c; t = c; b = c; f = c; k = c;
    nx = 0; ny = 0; nz = 0;
    if (x > 0) begin l = c - 1; nx++; end
    if (x + 1 < sx) begin r = c + 1; nx++; end
    if (y > 0) begin t = c - sx; ny++; end
    if (y + 1 < sy) begin b = c + sx; ny++; end
    if (z > 0) begin f = c - plane; nz++; end
    if (z + 1 < sz) begin k = c + plane; nz++; end
    ax = dir_term(win_read(l, has_new, val), win_read(r, has_new, val), nx);
    ay = dir_term(win_read(t, has_new, val), win_read(b, has_new, val), ny);
    az = dir_term(win_read(f, has_new, val), win_read(k, has_new, val), nz);
    s = longint'(ax) * ax + longint'(ay) * ay + longint'(az) * az;
    if (s == 0) begin
      n.gx = QMid; n.gy = QMid; n.gz = QMid;
    end else begin
      n.gx = quantize(ax, s);
      n.gy = quantize(ay, s);
      n.gz = quantize(az, s);
    end
    n.voxel = 8'(win_read(c, has_new, val));
    n.last = (c + 1 == plane * sz);
    return n;
  endfunction

  task automatic predict_item(voxel_item_t it);
    int unsigned plane, total;
    bit produced;
    plane = eff_size(size_reg[0]) * eff_size(size_reg[1]);
    total = plane * eff_size(size_reg[2]);
    produced = 0;
    if (it.kind == KindVoxel) begin
      if (in_pos >= total) return;
      if (out_pos + plane == in_pos) begin
        expected_normals = {expected_normals, gradient_at(1, it.value)};
        produced = 1;
      end
      win_mem[in_pos % WinDepth] = it.value;
      in_pos++;
    end else begin
      if (in_pos != total || out_pos >= total) return;
      expected_normals = {expected_normals, gradient_at(0, 0)};
      produced = 1;
    end
    if (!produced) return;
    out_pos++;
    if (out_pos >= total) begin
      in_pos = 0;
      out_pos = 0;
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
  endtask

  // driver: hold a stalled item, otherwise advance or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      kind_i <= KindVoxel;
      value_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) predict_item('{kind: kind_i, value: value_i});
      if (!in_valid_i || !in_stall_o) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          voxel_item_t it;
          it = pending_items.pop_front();
          in_valid_i <= 1'b1;
          kind_i <= it.kind;
          value_i <= it.value;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      if (out_valid_o && !out_stall_i) begin
        if (expected_normals.size() == 0) begin
          report_mismatch("unexpected item, voxel", voxel_o, -1);
        end else begin
          normal_t e;
          e = expected_normals.pop_front();
          if (grad_x_o !== e.gx) report_mismatch("grad_x", grad_x_o, e.gx);
          if (grad_y_o !== e.gy) report_mismatch("grad_y", grad_y_o, e.gy);
          if (grad_z_o !== e.gz) report_mismatch("grad_z", grad_z_o, e.gz);
          if (voxel_o !== e.voxel) report_mismatch("voxel", voxel_o, e.voxel);
          if (last_o !== e.last) report_mismatch("last", last_o, e.last);
        end
      end
    end
  end

  task automatic write_size(logic [CfgIdxW-1:0] idx, logic [7:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx != CfgIdxUnused) begin
      size_reg[idx] = data;
      in_pos = 0;
      out_pos = 0;
    end
    // keep the enable low before the next write
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_size();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd2;
      default: return 8'($urandom_range(2, 6));
    endcase
  endfunction

  task automatic add_item(logic kind, logic [7:0] value);
    pending_items = {pending_items, voxel_item_t'{kind: kind, value: value}};
  endtask

  // one volume; mostly well-formed, some with stray flushes, an extra voxel or cut short
  task automatic add_volume(int unsigned total, int unsigned plane, int style, ref int count);
    int unsigned n;
    int unsigned base, slope;
    base = $urandom_range(255);
    slope = $urandom_range(1, 40);
    if ($urandom_range(9) == 0) begin
      add_item(KindFlush, 8'($urandom));
      count++;
    end
    n = ($urandom_range(9) == 0) ? $urandom_range(total) : total;
    for (int unsigned i = 0; i < n; i++) begin
      case (style)
        0: add_item(KindVoxel, 8'($urandom));
        1: add_item(KindVoxel, 8'(base));
        2: add_item(KindVoxel, 8'(base + slope * i));
        default: add_item(KindVoxel, ($urandom_range(1)) ? 8'hFF : 8'h00);
      endcase
      count++;
    end
    if (n == total && $urandom_range(9) == 0) begin
      add_item(KindVoxel, 8'($urandom));
      count++;
    end
    n = ($urandom_range(9) == 0) ? $urandom_range(plane + 2) : plane + $urandom_range(1);
    for (int unsigned i = 0; i < n; i++) begin
      add_item(KindFlush, 8'($urandom));
      count++;
    end
  endtask

  initial begin
    logic [7:0] sz[3];
    int unsigned plane, total;
    int count;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_SIZE_X;
    cfg_wdata_i = '0;
    for (int i = 0; i < WinDepth; i++) win_mem[i] = '0;
    in_pos = 0;
    out_pos = 0;
    for (int i = 0; i < 3; i++) size_reg[i] = SizeReset;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < NumPhases; ph++) begin
      repeat (4) @(posedge clk_i);
      case (ph)
        0: sz = '{8'd3, 8'd3, 8'd3};
        1: sz = '{8'd255, 8'd1, 8'd2};
        2: sz = '{8'd1, 8'd1, 8'd1};
        3: sz = '{8'd1, 8'd128, 8'd1};
        4: sz = '{8'd0, 8'd1, 8'd128};
        default: sz = '{pick_size(), pick_size(), pick_size()};
      endcase
      write_size(CFG_SIZE_X, sz[0]);
      write_size(CFG_SIZE_Y, sz[1]);
      write_size(CFG_SIZE_Z, sz[2]);
      if (ph % 3 == 1) write_size(CfgIdxUnused, 8'($urandom));
      repeat (4) @(posedge clk_i);
      case (ph % 5)
        1: begin send_idle_pct = 49; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 49; end
        3: begin send_idle_pct = 25; recv_stall_pct = 25; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      plane = eff_size(sz[0]) * eff_size(sz[1]);
      total = plane * eff_size(sz[2]);
      count = 0;
      if (ph == 0) begin
        // extremes next to each other in one clean volume, then random volumes
        for (int unsigned i = 0; i < total; i++)
          add_item(KindVoxel, (i % 2) ? 8'hFF : 8'h00);
        for (int unsigned i = 0; i < plane; i++) add_item(KindFlush, 8'hFF);
        count = total + plane;
      end
      while (count < PhaseItems) add_volume(total, plane, $urandom_range(3), count);
      wait (pending_items.size() == 0 && !in_valid_i && expected_normals.size() == 0);
      repeat (DrainCycles) @(posedge clk_i);
    end

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
